// ----- rtl/transform_snapshot_interpolator_core_assert.svh -----
// Assertion macros used by the checker module.
`ifndef TRANSFORM_SNAPSHOT_INTERPOLATOR_CORE_ASSERT_SVH
`define TRANSFORM_SNAPSHOT_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TSI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tsi assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tsi assertion failed");

// Next-cycle implication that also runs during reset.
`define TSI_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tsi assertion failed");

`endif

// ----- rtl/tsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_pkg
// Constants, codes and arithmetic helpers of the transform snapshot
// interpolator.
// ----------------------------------------------------------------------------
package tsi_pkg;

    localparam int ALPHA_ONE  = 65536;
    localparam int FRAC_W     = $clog2(ALPHA_ONE);
    localparam int ALPHA_W    = FRAC_W + 1;
    localparam int POS_PROD_W = 33 + ALPHA_W + 1;
    localparam int ANG_PROD_W = 32 + ALPHA_W + 1;

    localparam int S_TDATA_W  = 208;
    localparam int M_TDATA_W  = 192;
    localparam int ANG_LSB    = 96;
    localparam int REM_LSB    = 192;
    localparam int PHASE_LSB  = 200;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TELEPORT_THR = CFG_IDX_W'(1);

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [6:0] REM_SAT = 7'd64;

    function automatic logic [ALPHA_W-1:0] alpha_calc(
        input logic       mode,
        input logic [7:0] rem,
        input logic [1:0] phase
    );
        logic [6:0]  sat;
        logic [1:0]  quarters;
        logic [8:0]  units;
        logic [31:0] w;
        sat      = (rem > 8'(REM_SAT)) ? REM_SAT : rem[6:0];
        quarters = phase - 2'd1;
        units    = {quarters, 6'd0} + 9'(sat);
        if (mode == 1'b0) begin
            w = 32'(sat) * 32'(ALPHA_ONE / 64);
        end else begin
            w = 32'(units) * 32'(ALPHA_ONE / 256);
        end
        if (w > 32'(ALPHA_ONE)) begin
            w = 32'(ALPHA_ONE);
        end
        return w[ALPHA_W-1:0];
    endfunction

    function automatic logic [31:0] mix_pos(
        input logic [31:0]        a,
        input logic [31:0]        b,
        input logic [ALPHA_W-1:0] w
    );
        logic signed [32:0]           d;
        logic signed [POS_PROD_W-1:0] prod;
        logic signed [POS_PROD_W-1:0] adj;
        logic signed [POS_PROD_W-1:0] q;
        d    = $signed({b[31], b}) - $signed({a[31], a});
        prod = d * $signed({1'b0, w});
        adj  = prod[POS_PROD_W-1] ? prod + POS_PROD_W'(ALPHA_ONE - 1) : prod;
        q    = adj >>> FRAC_W;
        return a + q[31:0];
    endfunction

    function automatic logic [31:0] mix_ang(
        input logic [31:0]        a,
        input logic [31:0]        b,
        input logic [ALPHA_W-1:0] w
    );
        logic signed [31:0]           s;
        logic signed [ANG_PROD_W-1:0] prod;
        logic signed [ANG_PROD_W-1:0] adj;
        logic signed [ANG_PROD_W-1:0] q;
        s    = $signed(b - a);
        prod = s * $signed({1'b0, w});
        adj  = prod[ANG_PROD_W-1] ? prod + ANG_PROD_W'(ALPHA_ONE - 1) : prod;
        q    = adj >>> FRAC_W;
        return a + q[31:0];
    endfunction

    function automatic logic jump(
        input logic [31:0]           a,
        input logic [31:0]           b,
        input logic [CFG_DATA_W-1:0] thr
    );
        logic signed [32:0] d;
        logic [32:0]        mag;
        d   = $signed({b[31], b}) - $signed({a[31], a});
        mag = d[32] ? 33'(-d) : 33'(d);
        return mag > 33'(thr);
    endfunction

endpackage

// ----- rtl/transform_snapshot_interpolator_core.sv -----
`timescale 1ns / 1ps
// A query beat's result is loaded into the result register on m_tdata when the
// input register advances, which a stalled sink can delay. A push beat updates
// the snapshot pair in the cycle after acceptance. Throughput: one beat per cycle
// while the sink is ready; set by the single input and result register pair.
// Reset: synchronous active-low aresetn clears both snapshots to zero,
// alpha_mode to 0, teleport_threshold to 0x7fffffff and all valid flags.
// ----------------------------------------------------------------------------
// transform_snapshot_interpolator_core
// Two-snapshot transform store with linear position and shortest-path angle
// interpolation and a teleport flag set when any position axis jumps.
// ----------------------------------------------------------------------------
module transform_snapshot_interpolator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, pos_z, ang_yaw, ang_pitch, ang_roll, tick_remainder,
    // tick_phase, zero pad
    input  logic [tsi_pkg::S_TDATA_W-1:0]       s_tdata,
    // op
    input  logic                                s_tuser,
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_x, out_y, out_z, out_yaw, out_pitch, out_roll
    output logic [tsi_pkg::M_TDATA_W-1:0]       m_tdata,
    // teleport
    output logic                                m_tuser,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tsi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsi_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tsi_pkg::*;

    logic                  alpha_mode_reg;
    logic [CFG_DATA_W-1:0] teleport_thr_reg;

    logic                  st1_valid_reg;
    logic                  st1_op_reg;
    logic [S_TDATA_W-1:0]  st1_data_reg;

    logic [31:0]           older_pos_reg [3];
    logic [31:0]           older_ang_reg [3];
    logic [31:0]           newer_pos_reg [3];
    logic [31:0]           newer_ang_reg [3];

    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic                  out_tp_reg;

    logic                  advance;
    logic [ALPHA_W-1:0]    alpha;
    logic [M_TDATA_W-1:0]  out_data_next;
    logic                  out_tp_next;
    logic [2:0]            axis_jump;

    assign advance  = st1_valid_reg &&
                      (st1_op_reg == OP_PUSH || !out_valid_reg || m_tready);
    assign s_tready = aresetn && (!st1_valid_reg || advance);
    assign cfg_ready = aresetn;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_tp_reg;

    always_comb begin
        alpha = alpha_calc(alpha_mode_reg, st1_data_reg[REM_LSB +: 8],
                           st1_data_reg[PHASE_LSB +: 2]);
        for (int i = 0; i < 3; i++) begin
            out_data_next[32*i +: 32] =
                mix_pos(older_pos_reg[i], newer_pos_reg[i], alpha);
            out_data_next[ANG_LSB + 32*i +: 32] =
                mix_ang(older_ang_reg[i], newer_ang_reg[i], alpha);
            axis_jump[i] = jump(older_pos_reg[i], newer_pos_reg[i], teleport_thr_reg);
        end
        out_tp_next = |axis_jump;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_mode_reg   <= 1'b0;
            teleport_thr_reg <= '1;
            st1_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                older_pos_reg[i] <= '0;
                older_ang_reg[i] <= '0;
                newer_pos_reg[i] <= '0;
                newer_ang_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ALPHA_MODE:   alpha_mode_reg   <= cfg_data[0];
                    REG_TELEPORT_THR: teleport_thr_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                st1_valid_reg <= 1'b1;
            end else if (advance) begin
                st1_valid_reg <= 1'b0;
            end

            // advance the pending beat: push updates state, query loads result
            if (advance && st1_op_reg == OP_PUSH) begin
                for (int i = 0; i < 3; i++) begin
                    older_pos_reg[i] <= newer_pos_reg[i];
                    older_ang_reg[i] <= newer_ang_reg[i];
                    newer_pos_reg[i] <= st1_data_reg[32*i +: 32];
                    newer_ang_reg[i] <= st1_data_reg[ANG_LSB + 32*i +: 32];
                end
            end

            if (advance && st1_op_reg == OP_QUERY) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            st1_op_reg   <= s_tuser;
            st1_data_reg <= s_tdata;
        end
        if (advance && st1_op_reg == OP_QUERY) begin
            out_data_reg <= out_data_next;
            out_tp_reg   <= out_tp_next;
        end
    end

endmodule

// ----- rtl/tsi_checker.sv -----
`timescale 1ns / 1ps
`include "transform_snapshot_interpolator_core_assert.svh"
// ----------------------------------------------------------------------------
// tsi_checker
// Port-level checks of the transform snapshot interpolator, bound to the top.
// ----------------------------------------------------------------------------
module tsi_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [tsi_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                m_tuser
);
    import tsi_pkg::*;

    logic q_beat;
    assign q_beat = s_tvalid && s_tready && s_tuser == OP_QUERY;

    // hold a stalled result beat
    `TSI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // drop the result channel out of reset
    `TSI_ASSERT_ALWAYS_NEXT(a_reset_idle, aclk, !aresetn, !m_tvalid)

    // a fresh result beat comes from a query that passed the input and result registers
    `TSI_ASSERT_NOW(a_rise_from_query, aclk, aresetn, $rose(m_tvalid),
        $past(q_beat, 2))

    // a ready sink never stalls the input side
    `TSI_ASSERT_NOW(a_flow_through, aclk, aresetn, m_tready, s_tready)

endmodule

bind transform_snapshot_interpolator_core tsi_checker u_tsi_checker (.*);
